@@ rtl/unique_key_fifo_unit_macros.svh @@
// assertion macros shared by the unique key fifo rtl
// no dependencies; included by the files that carry assertions
`ifndef UNIQUE_KEY_FIFO_UNIT_MACROS_SVH
`define UNIQUE_KEY_FIFO_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// property checked at every clock edge outside reset
`define UKF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// consequence expected in the cycle after the trigger
`define UKF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define UKF_ASSERT(lbl, clk, rstn, prop, msg)
`define UKF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

@@ rtl/ukf_pkg.sv @@
// shared types and codes of the unique key fifo
// no dependencies
package ukf_pkg;

  localparam int KEY_W = 32;
  localparam int POS_W = 5;
  localparam int CNT_W = 5;
  localparam int ST_W  = 3;

  localparam logic [1:0] FUNC_ENQ  = 2'd0;
  localparam logic [1:0] FUNC_DEQ  = 2'd1;
  localparam logic [1:0] FUNC_PEEK = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 3'd0;
  localparam logic [ST_W-1:0] ST_DUP   = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 3'd2;
  localparam logic [ST_W-1:0] ST_EMPTY = 3'd3;
  localparam logic [ST_W-1:0] ST_RANGE = 3'd4;

  typedef struct packed {
    logic [1:0]              func;
    logic signed [KEY_W-1:0] key;
    logic signed [KEY_W-1:0] value;
    logic [POS_W-1:0]        position;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic signed [KEY_W-1:0] key_out;
    logic signed [KEY_W-1:0] value_out;
    logic [CNT_W-1:0]        count;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic            load;
    logic            scan_init;
    logic            scan_issue;
    logic            rd_issue;
    logic            finish;
    logic [ST_W-1:0] fin_status;
    logic            wr_enq;
    logic            pop;
    logic            take_key;
    logic            take_value;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] func;
    logic       full;
    logic       empty;
    logic       range_err;
    logic       key_hit;
    logic       scan_done;
  } dp_stat_t;

endpackage

@@ rtl/ukf_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module ukf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/ukf_ctrl.sv @@
// sequencing state machine of the unique key fifo
// depends on ukf_pkg
module ukf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  ukf_pkg::dp_stat_t stat_i,
  output ukf_pkg::ctl_cmd_t cmd_o,
  output logic              busy
);

  import ukf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECIDE = 4'b0010,
    S_SCAN   = 4'b0100,
    S_RDWAIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd_o     = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_nxt  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (stat_i.func)
          FUNC_ENQ: begin
            if (stat_i.full) begin
              cmd_o.finish     = 1'b1;
              cmd_o.fin_status = ST_FULL;
              state_nxt        = S_IDLE;
            end else begin
              cmd_o.scan_init = 1'b1;
              state_nxt       = S_SCAN;
            end
          end
          FUNC_DEQ: begin
            if (stat_i.empty) begin
              cmd_o.finish     = 1'b1;
              cmd_o.fin_status = ST_EMPTY;
              state_nxt        = S_IDLE;
            end else begin
              cmd_o.rd_issue = 1'b1;
              state_nxt      = S_RDWAIT;
            end
          end
          FUNC_PEEK: begin
            if (stat_i.range_err) begin
              cmd_o.finish     = 1'b1;
              cmd_o.fin_status = ST_RANGE;
              state_nxt        = S_IDLE;
            end else begin
              cmd_o.rd_issue = 1'b1;
              state_nxt      = S_RDWAIT;
            end
          end
          default: begin
            // unused code: plain ok with no change
            cmd_o.finish     = 1'b1;
            cmd_o.fin_status = ST_OK;
            state_nxt        = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        if (stat_i.key_hit) begin
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = ST_DUP;
          state_nxt        = S_IDLE;
        end else if (stat_i.scan_done) begin
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = ST_OK;
          cmd_o.wr_enq     = 1'b1;
          state_nxt        = S_IDLE;
        end else begin
          cmd_o.scan_issue = 1'b1;
        end
      end
      S_RDWAIT: begin
        cmd_o.finish     = 1'b1;
        cmd_o.fin_status = ST_OK;
        cmd_o.take_key   = 1'b1;
        if (stat_i.func == FUNC_DEQ) begin
          cmd_o.pop = 1'b1;
        end else begin
          cmd_o.take_value = 1'b1;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

@@ rtl/ukf_dp.sv @@
// datapath of the unique key fifo: item register, ring pointers, store, result register
// depends on ukf_pkg, ukf_ram and unique_key_fifo_unit_macros.svh
`include "unique_key_fifo_unit_macros.svh"

module ukf_dp #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ukf_pkg::in_item_t  in_item,
  input  ukf_pkg::ctl_cmd_t  cmd_i,
  output ukf_pkg::dp_stat_t  stat_o,
  output logic               out_valid,
  output ukf_pkg::out_item_t out_item
);

  import ukf_pkg::*;

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  in_item_t             item_r;
  logic [AW-1:0]        head_r, head_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        rd_idx_r;
  logic                 cmp_valid_r;
  logic                 out_valid_r;
  out_item_t            out_item_r;

  logic [POS_W-1:0]     peek_idx;
  logic [CW-1:0]        rd_off;
  logic [AW-1:0]        raddr, waddr;
  logic [2*KEY_W-1:0]   rdata;
  logic signed [KEY_W-1:0] rd_key, rd_value;

  // ring slot of an offset from head; sum stays below twice the depth
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                            input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(head) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign peek_idx = (item_r.position == '0) ? '0 : item_r.position - POS_W'(1);

  always_comb begin
    if (cmd_i.scan_issue) begin
      rd_off = rd_idx_r;
    end else if (cmd_i.rd_issue && item_r.func == FUNC_PEEK) begin
      // only used when in range, so the index fits the count width
      rd_off = CW'(peek_idx);
    end else begin
      rd_off = '0;
    end
  end

  assign raddr = slot_of(head_r, rd_off);
  assign waddr = slot_of(head_r, count_r);

  ukf_ram #(
    .WIDTH(2 * KEY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd_i.wr_enq),
    .waddr (waddr),
    .wdata ({item_r.key, item_r.value}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_key   = rdata[2*KEY_W-1:KEY_W];
  assign rd_value = rdata[KEY_W-1:0];

  always_comb begin
    stat_o.func      = item_r.func;
    stat_o.full      = (count_r == CW'(DEPTH));
    stat_o.empty     = (count_r == '0);
    stat_o.range_err = (CMPW'(peek_idx) >= CMPW'(count_r));
    stat_o.key_hit   = cmp_valid_r && (rd_key == item_r.key);
    stat_o.scan_done = (rd_idx_r == count_r);
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd_i.wr_enq) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd_i.pop) begin
      count_nxt = count_r - CW'(1);
      head_nxt  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      rd_idx_r    <= '0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= cmd_i.finish;
      if (cmd_i.scan_init) begin
        rd_idx_r    <= '0;
        cmp_valid_r <= 1'b0;
      end else if (cmd_i.scan_issue) begin
        rd_idx_r    <= rd_idx_r + CW'(1);
        cmp_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      item_r <= in_item;
    end
    if (cmd_i.finish) begin
      out_item_r.status    <= cmd_i.fin_status;
      out_item_r.key_out   <= cmd_i.take_key ? rd_key : '0;
      out_item_r.value_out <= cmd_i.take_value ? rd_value : '0;
      out_item_r.count     <= CNT_W'(count_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `UKF_ASSERT(a_count_bound, clk, rst_n, count_r <= CW'(DEPTH), "entry count above depth")
  `UKF_ASSERT(a_pop_nonempty, clk, rst_n, !(cmd_i.pop && stat_o.empty), "pop of empty store")
  `UKF_ASSERT_NEXT(a_enq_grows, clk, rst_n, cmd_i.wr_enq, count_r == $past(count_r) + CW'(1), "enqueue did not grow count")

endmodule

@@ rtl/unique_key_fifo_unit.sv @@
// top level of the unique key fifo: fifo of key/value pairs with unique keys
// depends on ukf_pkg, ukf_ctrl, ukf_dp and unique_key_fifo_unit_macros.svh
//
// usage:
//   drive in_item and raise start; the item is taken at an edge where busy is low.
//   func selects enqueue, dequeue of the head, or peek at a position from the head.
//   exactly one result per item: out_valid is high for one cycle with out_item,
//   which carries status, key_out, value_out and the count after the item.
// sequence, from the accepting edge until busy falls:
//   enqueue: a decide state, then the duplicate scan, which reads one stored
//   key per cycle through the single read port of the store
//   dequeue and peek: a decide state, then one registered store read
//   full, empty, out of range and the unused code: the decide state alone
//   out_valid rises on the edge at which busy falls.
// reset (rst_n low, synchronous) empties the store; stored data is not cleared.
// the receiver cannot stall: each result must be taken in its strobe cycle.
`include "unique_key_fifo_unit_macros.svh"

module unique_key_fifo_unit #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ukf_pkg::in_item_t  in_item,
  output logic               out_valid,
  output ukf_pkg::out_item_t out_item
);

  import ukf_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  ukf_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  ukf_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  `UKF_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted item did not raise busy")
  `UKF_ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid, !out_valid, "result strobe longer than one cycle")

endmodule
